// ===== rtl/core/psc_pkg.sv =====
package psc_pkg;

  // Field widths
  localparam int COORD_W  = 24;
  localparam int EDIFF_W  = 25;
  localparam int DIFF_W   = 27;
  localparam int SDIFF_W  = 29;
  localparam int WEIGHT_W = 16;
  localparam int GRAD_W   = 48;
  localparam int COST_W   = 63;
  localparam int IDX_W    = 12;

  // Shared multiplier operand and product widths
  localparam int MUL_W  = 30;
  localparam int PROD_W = 2 * MUL_W;

  // Cost work widths
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int HALF_W  = DIFF_W;
  localparam int PART_W  = HALF_W + WEIGHT_W;
  localparam int GPART_W = GRAD_W - 1;

  localparam int MAX_POINTS_DEF = 4096;

  localparam logic [IDX_W-1:0]  IDX_MAX  = {IDX_W{1'b1}};
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = WEIGHT_W;

  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_EN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_W  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REF_W     = 2'd3;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;

  // Datapath operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
  localparam logic [OP_W-1:0] OP_SQ    = 4'd2;
  localparam logic [OP_W-1:0] OP_LO    = 4'd3;
  localparam logic [OP_W-1:0] OP_HI    = 4'd4;
  localparam logic [OP_W-1:0] OP_SUMT  = 4'd5;
  localparam logic [OP_W-1:0] OP_ACC   = 4'd6;
  localparam logic [OP_W-1:0] OP_GPREP = 4'd7;
  localparam logic [OP_W-1:0] OP_GS    = 4'd8;
  localparam logic [OP_W-1:0] OP_GR    = 4'd9;
  localparam logic [OP_W-1:0] OP_GSUM  = 4'd10;
  localparam logic [OP_W-1:0] OP_OUT   = 4'd11;
  localparam logic [OP_W-1:0] OP_END   = 4'd12;

  // Cost terms, in the order they are accumulated
  localparam logic [1:0] TERM_EX  = 2'd0;
  localparam logic [1:0] TERM_EY  = 2'd1;
  localparam logic [1:0] TERM_NDX = 2'd2;
  localparam logic [1:0] TERM_NDY = 2'd3;

  // Results an item may produce, in output order
  localparam logic [1:0] RES_A = 2'd0;
  localparam logic [1:0] RES_B = 2'd1;
  localparam logic [1:0] RES_C = 2'd2;

  localparam logic DIM_X = 1'b0;
  localparam logic DIM_Y = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [1:0]      term;
    logic [1:0]      res;
    logic            dim;
  } psc_cmd_t;

  typedef struct packed {
    logic smooth_en;
    logic ref_en;
    logic k_ge1;
    logic k_ge2;
    logic fin;
    logic out_free;
  } psc_stat_t;

endpackage

// ===== rtl/core/path_smoothing_cost_gradient.sv =====
// The block takes one point at a time and stalls its input until that point is done. The single
// shared 30x30 multiplier sets the pace: each enabled cost term takes 5 steps, each
// gradient result 10 steps (select, two dimensions of smoothness and reference products and
// sum, output); a stalled receiver adds its stall cycles on top.
// Reset (rst_n low, synchronous): registers to defaults, path window and cost cleared,
// output empty, input ready on the next cycle.
module path_smoothing_cost_gradient #(
  parameter int MAX_POINTS = psc_pkg::MAX_POINTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [psc_pkg::COORD_W-1:0]    in_pos_x,
  input  logic signed [psc_pkg::COORD_W-1:0]    in_pos_y,
  input  logic signed [psc_pkg::COORD_W-1:0]    in_target_x,
  input  logic signed [psc_pkg::COORD_W-1:0]    in_target_y,
  input  logic                                  in_final_point,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [psc_pkg::GRAD_W-1:0]     out_grad_x,
  output logic signed [psc_pkg::GRAD_W-1:0]     out_grad_y,
  output logic [psc_pkg::IDX_W-1:0]             out_point_number,
  output logic [psc_pkg::COST_W-1:0]            out_running_cost,
  output logic                                  out_final_result,
  input  logic                                  cfg_we,
  input  logic [psc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [psc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  psc_pkg::psc_cmd_t  cmd;
  psc_pkg::psc_stat_t stat;

  // Sequencer
  psc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Window, cost accumulator, shared multiplier and output register
  psc_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_target_x      (in_target_x),
    .in_target_y      (in_target_y),
    .in_final_point   (in_final_point),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_grad_x       (out_grad_x),
    .out_grad_y       (out_grad_y),
    .out_point_number (out_point_number),
    .out_running_cost (out_running_cost),
    .out_final_result (out_final_result)
  );

endmodule

// ===== rtl/core/psc_ctrl.sv =====
module psc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  psc_pkg::psc_stat_t  stat,
  output psc_pkg::psc_cmd_t   cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TERM  = 4'd1;
  localparam logic [3:0] S_LO    = 4'd2;
  localparam logic [3:0] S_HI    = 4'd3;
  localparam logic [3:0] S_SUMT  = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_RES   = 4'd6;
  localparam logic [3:0] S_GPREP = 4'd7;
  localparam logic [3:0] S_GS    = 4'd8;
  localparam logic [3:0] S_GR    = 4'd9;
  localparam logic [3:0] S_GSUM  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;
  localparam logic [3:0] S_END   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [1:0] term_r, term_nxt;
  logic [1:0] res_r, res_nxt;
  logic       dim_r, dim_nxt;
  logic       term_en;
  logic       res_apply;
  logic       last_term;

  // Term enable and result presence for the current step
  always_comb begin
    term_en = (term_r inside {psc_pkg::TERM_EX, psc_pkg::TERM_EY}) ? stat.ref_en
                                                                    : stat.smooth_en;
    case (res_r)
      psc_pkg::RES_A: res_apply = stat.k_ge2;
      psc_pkg::RES_B: res_apply = stat.fin & stat.k_ge1;
      default:        res_apply = stat.fin;
    endcase
  end

  assign last_term = (term_r == psc_pkg::TERM_NDY);

  // Sequence: load, the enabled ones of four cost terms, up to three results, window update or reset
  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    res_nxt   = res_r;
    dim_nxt   = dim_r;
    cmd.op    = psc_pkg::OP_NONE;
    cmd.term  = term_r;
    cmd.res   = res_r;
    cmd.dim   = dim_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = psc_pkg::OP_LOAD;
          term_nxt  = psc_pkg::TERM_EX;
          state_nxt = S_TERM;
        end
      end
      S_TERM: begin
        if (term_en) begin
          cmd.op    = psc_pkg::OP_SQ;
          state_nxt = S_LO;
        end else if (last_term) begin
          res_nxt   = psc_pkg::RES_A;
          state_nxt = S_RES;
        end else begin
          term_nxt  = term_r + 2'd1;
        end
      end
      S_LO: begin
        cmd.op    = psc_pkg::OP_LO;
        state_nxt = S_HI;
      end
      S_HI: begin
        cmd.op    = psc_pkg::OP_HI;
        state_nxt = S_SUMT;
      end
      S_SUMT: begin
        cmd.op    = psc_pkg::OP_SUMT;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op = psc_pkg::OP_ACC;
        if (last_term) begin
          res_nxt   = psc_pkg::RES_A;
          state_nxt = S_RES;
        end else begin
          term_nxt  = term_r + 2'd1;
          state_nxt = S_TERM;
        end
      end
      S_RES: begin
        if (res_apply) begin
          dim_nxt   = psc_pkg::DIM_X;
          state_nxt = S_GPREP;
        end else if (res_r == psc_pkg::RES_C) begin
          state_nxt = S_END;
        end else begin
          res_nxt   = res_r + 2'd1;
        end
      end
      S_GPREP: begin
        cmd.op    = psc_pkg::OP_GPREP;
        state_nxt = S_GS;
      end
      S_GS: begin
        cmd.op    = psc_pkg::OP_GS;
        state_nxt = S_GR;
      end
      S_GR: begin
        cmd.op    = psc_pkg::OP_GR;
        state_nxt = S_GSUM;
      end
      S_GSUM: begin
        cmd.op = psc_pkg::OP_GSUM;
        if (dim_r == psc_pkg::DIM_X) begin
          dim_nxt   = psc_pkg::DIM_Y;
          state_nxt = S_GPREP;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.op = psc_pkg::OP_OUT;
          if (res_r == psc_pkg::RES_C) begin
            state_nxt = S_END;
          end else begin
            res_nxt   = res_r + 2'd1;
            state_nxt = S_RES;
          end
        end
      end
      S_END: begin
        cmd.op    = psc_pkg::OP_END;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      term_r  <= psc_pkg::TERM_EX;
      res_r   <= psc_pkg::RES_A;
      dim_r   <= psc_pkg::DIM_X;
    end else begin
      state_r <= state_nxt;
      term_r  <= term_nxt;
      res_r   <= res_nxt;
      dim_r   <= dim_nxt;
    end
  end

endmodule

// ===== rtl/core/psc_datapath.sv =====
module psc_datapath #(
  parameter int MAX_POINTS = psc_pkg::MAX_POINTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  psc_pkg::psc_cmd_t                     cmd,
  output psc_pkg::psc_stat_t                    stat,
  input  logic                                  cfg_we,
  input  logic [psc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [psc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic signed [psc_pkg::COORD_W-1:0]    in_pos_x,
  input  logic signed [psc_pkg::COORD_W-1:0]    in_pos_y,
  input  logic signed [psc_pkg::COORD_W-1:0]    in_target_x,
  input  logic signed [psc_pkg::COORD_W-1:0]    in_target_y,
  input  logic                                  in_final_point,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [psc_pkg::GRAD_W-1:0]     out_grad_x,
  output logic signed [psc_pkg::GRAD_W-1:0]     out_grad_y,
  output logic [psc_pkg::IDX_W-1:0]             out_point_number,
  output logic [psc_pkg::COST_W-1:0]            out_running_cost,
  output logic                                  out_final_result
);

  localparam int CW = psc_pkg::COORD_W;
  localparam int DW = psc_pkg::DIFF_W;
  localparam int EW = psc_pkg::EDIFF_W;
  localparam int SW = psc_pkg::SDIFF_W;
  localparam int WW = psc_pkg::WEIGHT_W;
  localparam int MW = psc_pkg::MUL_W;
  localparam int HW = psc_pkg::HALF_W;
  localparam int PW = psc_pkg::PART_W;
  localparam int GW = psc_pkg::GRAD_W;
  localparam int GPW = psc_pkg::GPART_W;
  localparam int KW = psc_pkg::COST_W;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IW = (CNT_W > psc_pkg::IDX_W) ? CNT_W : psc_pkg::IDX_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

  // Configuration registers
  logic          smooth_en_r, ref_en_r;
  logic [WW-1:0] smooth_w_r, ref_w_r;

  // Path window state
  logic signed [CW-1:0] pp0x_r, pp1x_r, pp0y_r, pp1y_r;
  logic signed [CW-1:0] pt0x_r, pt1x_r, pt0y_r, pt1y_r;
  logic signed [DW-1:0] dh0x_r, dh1x_r, dh0y_r, dh1y_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [KW-1:0]        cost_r;

  // Current item
  logic signed [CW-1:0] cx_r, cy_r, ctx_r, cty_r;
  logic                 fin_r;
  logic [CNT_W-1:0]     k_r;
  logic signed [DW-1:0] ndx_r, ndy_r;
  logic signed [EW-1:0] ex_r, ey_r;

  // Work registers
  logic [psc_pkg::SQ_W-1:0] sq_r;
  logic [PW-1:0]            lo_r, hi_r;
  logic [KW-1:0]            term_r;
  logic signed [SW-1:0]     sd_r;
  logic signed [EW-1:0]     ge_r;
  logic signed [GPW-1:0]    gs_r, gr_r;
  logic signed [GW-1:0]     gx_r, gy_r;

  // Output register
  logic                 out_valid_r;
  logic signed [GW-1:0] out_gx_r, out_gy_r;
  logic [psc_pkg::IDX_W-1:0] out_idx_r;
  logic [KW-1:0]        out_cost_r;
  logic                 out_fin_r;

  // Second difference of the incoming point
  logic signed [DW-1:0] in_px_e, in_py_e, p0x_e, p0y_e, p1x_e, p1y_e;
  logic signed [DW-1:0] in_ndx, in_ndy;
  logic                 cnt_ge2;

  assign in_px_e = {{(DW-CW){in_pos_x[CW-1]}}, in_pos_x};
  assign in_py_e = {{(DW-CW){in_pos_y[CW-1]}}, in_pos_y};
  assign p0x_e   = {{(DW-CW){pp0x_r[CW-1]}}, pp0x_r};
  assign p0y_e   = {{(DW-CW){pp0y_r[CW-1]}}, pp0y_r};
  assign p1x_e   = {{(DW-CW){pp1x_r[CW-1]}}, pp1x_r};
  assign p1y_e   = {{(DW-CW){pp1y_r[CW-1]}}, pp1y_r};
  assign in_ndx  = in_px_e - {p0x_e[DW-2:0], 1'b0} + p1x_e;
  assign in_ndy  = in_py_e - {p0y_e[DW-2:0], 1'b0} + p1y_e;
  assign cnt_ge2 = (cnt_r > CNT_W'(1));

  // Select the per-dimension operands for a gradient
  logic signed [DW-1:0] dh1_s, dh0_s, nd_s, sd_m1, sd_d0, sd_p1;
  logic signed [CW-1:0] pp0_s, pp1_s, pt0_s, pt1_s, c_s, ct_s, e_p, e_t;
  logic signed [SW-1:0] m1_e, d0_e, p1_e, sd_val;

  always_comb begin
    if (cmd.dim == psc_pkg::DIM_X) begin
      dh1_s = dh1x_r; dh0_s = dh0x_r; nd_s = ndx_r;
      pp0_s = pp0x_r; pp1_s = pp1x_r; pt0_s = pt0x_r; pt1_s = pt1x_r;
      c_s   = cx_r;   ct_s  = ctx_r;
    end else begin
      dh1_s = dh1y_r; dh0_s = dh0y_r; nd_s = ndy_r;
      pp0_s = pp0y_r; pp1_s = pp1y_r; pt0_s = pt0y_r; pt1_s = pt1y_r;
      c_s   = cy_r;   ct_s  = cty_r;
    end
    case (cmd.res)
      psc_pkg::RES_A: begin
        sd_m1 = dh1_s; sd_d0 = dh0_s; sd_p1 = nd_s;
        e_p   = pp1_s; e_t   = pt1_s;
      end
      psc_pkg::RES_B: begin
        sd_m1 = dh0_s; sd_d0 = nd_s; sd_p1 = '0;
        e_p   = pp0_s; e_t   = pt0_s;
      end
      default: begin
        sd_m1 = nd_s; sd_d0 = '0; sd_p1 = '0;
        e_p   = c_s;  e_t   = ct_s;
      end
    endcase
  end

  assign m1_e   = {{(SW-DW){sd_m1[DW-1]}}, sd_m1};
  assign d0_e   = {{(SW-DW){sd_d0[DW-1]}}, sd_d0};
  assign p1_e   = {{(SW-DW){sd_p1[DW-1]}}, sd_p1};
  assign sd_val = m1_e - {d0_e[SW-2:0], 1'b0} + p1_e;

  // Shared multiplier operand select
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [psc_pkg::PROD_W-1:0] prod;
  logic signed [MW-1:0] term_v;
  logic [WW-1:0]        w_sel;

  always_comb begin
    case (cmd.term)
      psc_pkg::TERM_EX:  term_v = {{(MW-EW){ex_r[EW-1]}}, ex_r};
      psc_pkg::TERM_EY:  term_v = {{(MW-EW){ey_r[EW-1]}}, ey_r};
      psc_pkg::TERM_NDX: term_v = {{(MW-DW){ndx_r[DW-1]}}, ndx_r};
      default:           term_v = {{(MW-DW){ndy_r[DW-1]}}, ndy_r};
    endcase
    w_sel = (cmd.term inside {psc_pkg::TERM_EX, psc_pkg::TERM_EY}) ? ref_w_r : smooth_w_r;
    case (cmd.op)
      psc_pkg::OP_SQ: begin
        mul_a = term_v;
        mul_b = term_v;
      end
      psc_pkg::OP_LO: begin
        mul_a = {{(MW-HW){1'b0}}, sq_r[HW-1:0]};
        mul_b = {{(MW-WW){1'b0}}, w_sel};
      end
      psc_pkg::OP_HI: begin
        mul_a = {{(MW-HW){1'b0}}, sq_r[2*HW-1:HW]};
        mul_b = {{(MW-WW){1'b0}}, w_sel};
      end
      psc_pkg::OP_GS: begin
        mul_a = {{(MW-SW){sd_r[SW-1]}}, sd_r};
        mul_b = {{(MW-WW-1){1'b0}}, smooth_w_r, 1'b0};
      end
      psc_pkg::OP_GR: begin
        mul_a = {{(MW-EW){ge_r[EW-1]}}, ge_r};
        mul_b = {{(MW-WW-1){1'b0}}, ref_w_r, 1'b0};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Weighted square reassembly, cost accumulation and saturated gradient sum
  logic [PW+HW:0] term_sum;
  logic [KW:0]    cost_sum;
  logic signed [GW:0] g_sum;
  logic signed [GW-1:0] g_sat;

  assign term_sum = {1'b0, hi_r, {HW{1'b0}}} + {{(HW+1){1'b0}}, lo_r};
  assign cost_sum = {1'b0, cost_r} + {1'b0, term_r};
  assign g_sum    = {{(GW+1-GPW){gs_r[GPW-1]}}, gs_r}
                  + {{(GW+1-GPW){gr_r[GPW-1]}}, gr_r};

  always_comb begin
    if (g_sum[GW] != g_sum[GW-1]) begin
      g_sat = g_sum[GW] ? {1'b1, {(GW-1){1'b0}}} : {1'b0, {(GW-1){1'b1}}};
    end else begin
      g_sat = g_sum[GW-1:0];
    end
  end

  // Point number of the selected result, clamped to the field range
  logic [IW-1:0] k_ext, idx_w;
  logic [psc_pkg::IDX_W-1:0] idx_clamped;

  assign k_ext = IW'(k_r);
  always_comb begin
    case (cmd.res)
      psc_pkg::RES_A: idx_w = k_ext - IW'(2);
      psc_pkg::RES_B: idx_w = k_ext - IW'(1);
      default:        idx_w = k_ext;
    endcase
    idx_clamped = (idx_w > IW'(psc_pkg::IDX_MAX)) ? psc_pkg::IDX_MAX
                                                  : idx_w[psc_pkg::IDX_W-1:0];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_en_r <= 1'b1;
      ref_en_r    <= 1'b1;
      smooth_w_r  <= psc_pkg::WEIGHT_RESET;
      ref_w_r     <= psc_pkg::WEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        psc_pkg::REG_SMOOTH_EN: smooth_en_r <= cfg_wdata[0];
        psc_pkg::REG_REF_EN:    ref_en_r    <= cfg_wdata[0];
        psc_pkg::REG_SMOOTH_W:  smooth_w_r  <= cfg_wdata;
        psc_pkg::REG_REF_W:     ref_w_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Path window, point count and running cost
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp0x_r <= '0; pp1x_r <= '0; pp0y_r <= '0; pp1y_r <= '0;
      pt0x_r <= '0; pt1x_r <= '0; pt0y_r <= '0; pt1y_r <= '0;
      dh0x_r <= '0; dh1x_r <= '0; dh0y_r <= '0; dh1y_r <= '0;
      cnt_r  <= '0;
      cost_r <= '0;
    end else if (cmd.op == psc_pkg::OP_ACC) begin
      cost_r <= cost_sum[KW] ? psc_pkg::COST_MAX : cost_sum[KW-1:0];
    end else if (cmd.op == psc_pkg::OP_END) begin
      if (fin_r) begin
        // drop the path: back to the reset window
        pp0x_r <= '0; pp1x_r <= '0; pp0y_r <= '0; pp1y_r <= '0;
        pt0x_r <= '0; pt1x_r <= '0; pt0y_r <= '0; pt1y_r <= '0;
        dh0x_r <= '0; dh1x_r <= '0; dh0y_r <= '0; dh1y_r <= '0;
        cnt_r  <= '0;
        cost_r <= '0;
      end else begin
        // advance the window by one point
        pp1x_r <= pp0x_r; pp0x_r <= cx_r;
        pp1y_r <= pp0y_r; pp0y_r <= cy_r;
        pt1x_r <= pt0x_r; pt0x_r <= ctx_r;
        pt1y_r <= pt0y_r; pt0y_r <= cty_r;
        dh1x_r <= dh0x_r; dh0x_r <= ndx_r;
        dh1y_r <= dh0y_r; dh0y_r <= ndy_r;
        if (cnt_r < CNT_MAX) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  // Item capture and work registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      psc_pkg::OP_LOAD: begin
        cx_r  <= in_pos_x;
        cy_r  <= in_pos_y;
        ctx_r <= in_target_x;
        cty_r <= in_target_y;
        fin_r <= in_final_point;
        k_r   <= cnt_r;
        ndx_r <= cnt_ge2 ? in_ndx : '0;
        ndy_r <= cnt_ge2 ? in_ndy : '0;
        ex_r  <= {in_pos_x[CW-1], in_pos_x} - {in_target_x[CW-1], in_target_x};
        ey_r  <= {in_pos_y[CW-1], in_pos_y} - {in_target_y[CW-1], in_target_y};
      end
      psc_pkg::OP_SQ:   sq_r <= prod[psc_pkg::SQ_W-1:0];
      psc_pkg::OP_LO:   lo_r <= prod[PW-1:0];
      psc_pkg::OP_HI:   hi_r <= prod[PW-1:0];
      psc_pkg::OP_SUMT: begin
        term_r <= (|term_sum[PW+HW:KW]) ? psc_pkg::COST_MAX : term_sum[KW-1:0];
      end
      psc_pkg::OP_GPREP: begin
        sd_r <= sd_val;
        ge_r <= {e_p[CW-1], e_p} - {e_t[CW-1], e_t};
      end
      psc_pkg::OP_GS: gs_r <= smooth_en_r ? prod[GPW-1:0] : '0;
      psc_pkg::OP_GR: gr_r <= ref_en_r ? prod[GPW-1:0] : '0;
      psc_pkg::OP_GSUM: begin
        if (cmd.dim == psc_pkg::DIM_X) begin
          gx_r <= g_sat;
        end else begin
          gy_r <= g_sat;
        end
      end
      default: ;
    endcase
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == psc_pkg::OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == psc_pkg::OP_OUT) begin
      out_gx_r   <= gx_r;
      out_gy_r   <= gy_r;
      out_idx_r  <= idx_clamped;
      out_cost_r <= cost_r;
      out_fin_r  <= (cmd.res == psc_pkg::RES_C);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_grad_x       = out_gx_r;
  assign out_grad_y       = out_gy_r;
  assign out_point_number = out_idx_r;
  assign out_running_cost = out_cost_r;
  assign out_final_result = out_fin_r;

  // Status to the controller
  assign stat.smooth_en = smooth_en_r;
  assign stat.ref_en    = ref_en_r;
  assign stat.k_ge1     = (k_r != '0);
  assign stat.k_ge2     = (k_r > CNT_W'(1));
  assign stat.fin       = fin_r;
  assign stat.out_free  = !out_valid_r || !out_stall;

endmodule

// ===== rtl/core/psc_checker.sv =====
module psc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [psc_pkg::GRAD_W-1:0]        out_grad_x,
  input logic [psc_pkg::GRAD_W-1:0]        out_grad_y,
  input logic [psc_pkg::IDX_W-1:0]         out_point_number,
  input logic [psc_pkg::COST_W-1:0]        out_running_cost
);

  // A stalled output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_grad_x) && $stable(out_grad_y)
                               && $stable(out_point_number) && $stable(out_running_cost))
    else $error("stalled output word changed");

  // Reset empties the output and opens the input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // An accepted point keeps the input closed while it is worked on
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after an accepted point");

  // A new result appears only while a point is in progress
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_stall)
    else $error("result appeared with the block idle");

endmodule

bind path_smoothing_cost_gradient psc_checker u_psc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_grad_x       (out_grad_x),
  .out_grad_y       (out_grad_y),
  .out_point_number (out_point_number),
  .out_running_cost (out_running_cost)
);
